// File: rtl/core/oli_pkg.sv
// Shared constants, codes and control types of the list intersection block.
`default_nettype none

package oli_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int ACT_W       = 2;
  localparam int OUT_CNT_W   = 7;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PROBE = 2'd1,
    ACT_END   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_END
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_en;
    logic probe_start;
    logic scan_en;
    logic emit_en;
    logic end_en;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ref_empty;
    logic scan_last;
    logic hit;
    logic slot_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/oli_if.sv
// Valid/ready channel interfaces for input beats and result beats.
`default_nettype none

interface oli_in_if;
  logic                           valid;
  logic                           ready;
  logic [oli_pkg::ACT_W-1:0]      action;
  logic signed [oli_pkg::VAL_W-1:0] value_in;

  modport source (output valid, output action, output value_in, input ready);
  modport sink   (input valid, input action, input value_in, output ready);
  modport mon    (input valid, input action, input value_in, input ready);
endinterface

interface oli_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [oli_pkg::VAL_W-1:0]  value_out;
  logic                              is_end;
  logic [oli_pkg::OUT_CNT_W-1:0]     common_count;
  logic                              overflowed;

  modport source (output valid, output value_out, output is_end, output common_count,
                  output overflowed, input ready);
  modport sink   (input valid, input value_out, input is_end, input common_count,
                  input overflowed, output ready);
  modport mon    (input valid, input value_out, input is_end, input common_count,
                  input overflowed, input ready);
endinterface

`default_nettype wire

// File: rtl/core/ordered_list_intersection_unit.sv
// Top level of the ordered list intersection block.
// Load beats fill a 64-entry reference memory; probe beats are matched against it and
// against the values already emitted, and each first match is sent out in probe order.
// An end beat sends a closing result with the distinct match count and the overflow
// flag, then empties both stores. A probe walks the N reference entries loaded (N up
// to 64) with one registered read port per memory, one entry a cycle and a single
// compare each. A result waiting in the output register does not block the next beat,
// but a new result waits for it to drain.
`default_nettype none

module ordered_list_intersection_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  oli_in_if.sink     in_ch,
  oli_out_if.source  out_ch
);

  oli_pkg::cmd_t cmd;
  oli_pkg::sts_t sts;

  oli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .sts       (sts),
    .cmd       (cmd)
  );

  oli_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .value_in     (in_ch.value_in),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .value_out    (out_ch.value_out),
    .is_end       (out_ch.is_end),
    .common_count (out_ch.common_count),
    .overflowed   (out_ch.overflowed)
  );

endmodule

`default_nettype wire

// File: rtl/core/oli_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module oli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/oli_datapath.sv
// Datapath: reference and emitted stores, counts, scan compare and result register.
`default_nettype none

module oli_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire oli_pkg::cmd_t                      cmd,
  output oli_pkg::sts_t                           sts,
  input  wire logic signed [oli_pkg::VAL_W-1:0]   value_in,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [oli_pkg::VAL_W-1:0]        value_out,
  output logic                                    is_end,
  output logic [oli_pkg::OUT_CNT_W-1:0]           common_count,
  output logic                                    overflowed
);

  logic [oli_pkg::CNT_W-1:0]     ref_count_r;
  logic [oli_pkg::CNT_W-1:0]     emt_count_r;
  logic                          ovf_r;
  logic [oli_pkg::VAL_W-1:0]     val_r;
  logic [oli_pkg::CNT_W-1:0]     idx_r;
  logic [oli_pkg::CNT_W-1:0]     q_idx_r;
  logic                          q_vld_r;
  logic                          ref_hit_r;
  logic                          emt_hit_r;

  logic                          out_valid_r;
  logic [oli_pkg::VAL_W-1:0]     out_value_r;
  logic                          out_is_end_r;
  logic [oli_pkg::OUT_CNT_W-1:0] out_count_r;
  logic                          out_ovf_r;

  logic [oli_pkg::VAL_W-1:0]     ref_q;
  logic [oli_pkg::VAL_W-1:0]     emt_q;
  logic                          ref_full;
  logic                          emt_full;
  logic                          ref_we;
  logic                          emt_we;
  logic                          issue;
  logic                          ref_match;
  logic                          emt_match;
  logic                          slot_free;

  assign ref_full  = (ref_count_r == oli_pkg::CNT_W'(oli_pkg::STORE_DEPTH));
  assign emt_full  = (emt_count_r == oli_pkg::CNT_W'(oli_pkg::STORE_DEPTH));
  assign ref_we    = cmd.load_en && !ref_full;
  assign emt_we    = cmd.emit_en && !emt_full;
  assign issue     = cmd.scan_en && (idx_r < ref_count_r);
  // read data comes from the address of the previous cycle; q_idx_r tracks which entry it is
  assign ref_match = q_vld_r && (ref_q == val_r);
  assign emt_match = q_vld_r && (q_idx_r < emt_count_r) && (emt_q == val_r);
  assign slot_free = !out_valid_r || out_ready;

  oli_ram #(
    .WIDTH (oli_pkg::VAL_W),
    .DEPTH (oli_pkg::STORE_DEPTH)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (ref_count_r[oli_pkg::ADDR_W-1:0]),
    .wdata (value_in),
    .raddr (idx_r[oli_pkg::ADDR_W-1:0]),
    .rdata (ref_q)
  );

  oli_ram #(
    .WIDTH (oli_pkg::VAL_W),
    .DEPTH (oli_pkg::STORE_DEPTH)
  ) u_emt_ram (
    .clk   (clk),
    .we    (emt_we),
    .waddr (emt_count_r[oli_pkg::ADDR_W-1:0]),
    .wdata (val_r),
    .raddr (idx_r[oli_pkg::ADDR_W-1:0]),
    .rdata (emt_q)
  );

  // counts and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r <= '0;
      emt_count_r <= '0;
      ovf_r       <= 1'b0;
    end else if (cmd.end_en) begin
      ref_count_r <= '0;
      emt_count_r <= '0;
      ovf_r       <= 1'b0;
    end else begin
      if (cmd.load_en) begin
        if (ref_full) begin
          ovf_r <= 1'b1;
        end else begin
          ref_count_r <= ref_count_r + oli_pkg::CNT_W'(1);
        end
      end
      if (emt_we) begin
        emt_count_r <= emt_count_r + oli_pkg::CNT_W'(1);
      end
    end
  end

  // scan sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else if (cmd.probe_start) begin
      q_vld_r <= 1'b0;
    end else begin
      q_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_start) begin
      val_r     <= value_in;
      idx_r     <= '0;
      ref_hit_r <= 1'b0;
      emt_hit_r <= 1'b0;
    end else if (cmd.scan_en) begin
      if (issue) begin
        idx_r <= idx_r + oli_pkg::CNT_W'(1);
      end
      q_idx_r   <= idx_r;
      ref_hit_r <= ref_hit_r || ref_match;
      emt_hit_r <= emt_hit_r || emt_match;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_en || cmd.end_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_value_r  <= val_r;
      out_is_end_r <= 1'b0;
      out_count_r  <= '0;
      out_ovf_r    <= 1'b0;
    end else if (cmd.end_en) begin
      out_value_r  <= '0;
      out_is_end_r <= 1'b1;
      out_count_r  <= oli_pkg::OUT_CNT_W'(emt_count_r);
      out_ovf_r    <= ovf_r;
    end
  end

  assign sts.ref_empty = (ref_count_r == '0);
  assign sts.scan_last = q_vld_r && ((q_idx_r + oli_pkg::CNT_W'(1)) == ref_count_r);
  assign sts.hit       = ref_hit_r && !emt_hit_r;
  assign sts.slot_free = slot_free;

  assign out_valid    = out_valid_r;
  assign value_out    = out_value_r;
  assign is_end       = out_is_end_r;
  assign common_count = out_count_r;
  assign overflowed   = out_ovf_r;

endmodule

`default_nettype wire

// File: rtl/core/oli_ctrl.sv
// Controller state machine: takes beats, sequences probe scans and result pushes.
`default_nettype none

module oli_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [oli_pkg::ACT_W-1:0]   in_action,
  input  wire oli_pkg::sts_t               sts,
  output oli_pkg::cmd_t                    cmd
);

  oli_pkg::state_t state_r;
  oli_pkg::state_t state_nxt;
  logic            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oli_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == oli_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      oli_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_action)
            oli_pkg::ACT_LOAD: begin
              cmd.load_en = 1'b1;
            end
            oli_pkg::ACT_PROBE: begin
              cmd.probe_start = 1'b1;
              if (!sts.ref_empty) begin
                state_nxt = oli_pkg::ST_SCAN;
              end
            end
            oli_pkg::ACT_END: begin
              state_nxt = oli_pkg::ST_END;
            end
            default: begin
              // unused code: dropped
            end
          endcase
        end
      end
      oli_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = oli_pkg::ST_EMIT;
        end
      end
      oli_pkg::ST_EMIT: begin
        if (!sts.hit) begin
          state_nxt = oli_pkg::ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit_en = 1'b1;
          state_nxt   = oli_pkg::ST_IDLE;
        end
      end
      oli_pkg::ST_END: begin
        if (sts.slot_free) begin
          cmd.end_en = 1'b1;
          state_nxt  = oli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = oli_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/oli_checker.sv
// Port-level checker for the list intersection block, bound to the top level.
`default_nettype none

module oli_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire logic [oli_pkg::ACT_W-1:0]       in_action,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [oli_pkg::VAL_W-1:0]       out_value,
  input wire logic                            out_is_end,
  input wire logic [oli_pkg::OUT_CNT_W-1:0]   out_count,
  input wire logic                            out_ovf
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_end_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_value == '0)
    else $error("closing beat carries a value");

  a_match_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_end |-> out_count == '0 && !out_ovf)
    else $error("match beat carries closing fields");

  // an end beat always produces a result, so the input side must pause
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == oli_pkg::ACT_END |=> !in_ready)
    else $error("input taken while closing result pending");

endmodule

bind ordered_list_intersection_unit oli_checker u_oli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_action  (in_ch.action),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_value  (out_ch.value_out),
  .out_is_end (out_ch.is_end),
  .out_count  (out_ch.common_count),
  .out_ovf    (out_ch.overflowed)
);

`default_nettype wire
